>>> hw/rtl/assert_macros.svh
// assertion helpers, clocked on clock and muted while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define ASSERT_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/kcis_pkg.sv
package kcis_pkg;

   localparam int PATTERN_MAX     = 8;
   localparam int BYTE_WIDTH      = 8;
   localparam int KEY_WIDTH       = PATTERN_MAX * BYTE_WIDTH;
   localparam int LEN_WIDTH       = 4;
   localparam int POS_WIDTH       = $clog2(PATTERN_MAX + 1);
   localparam int SEL_WIDTH       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int VALUE_WIDTH     = 31;
   localparam int PROD_WIDTH      = VALUE_WIDTH + 4;
   localparam int DIGIT_WIDTH     = 4;
   localparam int STATUS_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = KEY_WIDTH;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

   // character codes
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [BYTE_WIDTH-1:0] CHAR_COLON   = 8'h3a;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE    = 8'h39;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_PATTERN = 1'b0,
      CSR_KEY_LENGTH  = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NO_KEY    = 2'd1,
      STATUS_NO_COLON  = 2'd2,
      STATUS_NO_DIGITS = 2'd3
   } status_type;

   // one finished scan, handed from the scanner to the output stage
   typedef struct packed {
      logic                   valid;
      logic [VALUE_WIDTH-1:0] value;
      status_type             status;
      logic                   overflow;
   } result_type;

   function automatic logic is_blank(input logic [BYTE_WIDTH-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE);
   endfunction

   function automatic logic is_digit(input logic [BYTE_WIDTH-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

>>> hw/rtl/kcis_if.sv
// text byte channel
interface kcis_req_if import kcis_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] text_byte;
   logic                  last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// scan result channel
interface kcis_rsp_if import kcis_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [VALUE_WIDTH-1:0]  number_value;
   logic [STATUS_WIDTH-1:0] scan_status;
   logic                    value_overflow;

   modport source (output valid, output number_value, output scan_status,
                   output value_overflow, input ready);
   modport sink   (input valid, input number_value, input scan_status,
                   input value_overflow, output ready);
endinterface

>>> hw/rtl/kcis_csr.sv
module kcis_csr import kcis_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output logic [KEY_WIDTH-1:0]       key_pattern,
   output logic [POS_WIDTH-1:0]       key_len
);

   logic [KEY_WIDTH-1:0] key_pattern_ff;
   logic [POS_WIDTH-1:0] key_len_ff;
   logic [LEN_WIDTH-1:0] len_raw;
   logic [POS_WIDTH-1:0] len_clamped;

   // clamp the length once, at write time
   assign len_raw = csr_write_data[LEN_WIDTH-1:0];

   always_comb begin
      if (len_raw == '0) begin
         len_clamped = POS_WIDTH'(1);
      end else if (LEN_WIDTH'(len_raw) > LEN_WIDTH'(PATTERN_MAX)) begin
         len_clamped = POS_WIDTH'(PATTERN_MAX);
      end else begin
         len_clamped = POS_WIDTH'(len_raw);
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_pattern_ff <= '0;
         key_len_ff     <= POS_WIDTH'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_PATTERN: key_pattern_ff <= csr_write_data[KEY_WIDTH-1:0];
            CSR_KEY_LENGTH:  key_len_ff     <= len_clamped;
            default: ;
         endcase
      end
   end

   assign key_pattern = key_pattern_ff;
   assign key_len     = key_len_ff;

endmodule

>>> hw/rtl/kcis_scan.sv
module kcis_scan import kcis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat_accept,
   input  logic [BYTE_WIDTH-1:0] text_byte,
   input  logic                  last_byte,
   input  logic [KEY_WIDTH-1:0]  key_pattern,
   input  logic [POS_WIDTH-1:0]  key_len,
   output result_type            result
);

   typedef enum logic [2:0] {
      PH_KEY    = 3'd0,
      PH_COLON  = 3'd1,
      PH_BLANK  = 3'd2,
      PH_DIGITS = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;

   logic [PATTERN_MAX-1:0][BYTE_WIDTH-1:0] key_bytes;
   logic                    hit;
   logic [POS_WIDTH-1:0]    pos_step;
   logic [VALUE_WIDTH-1:0]  acc_base;
   logic                    ovf_base;
   logic [DIGIT_WIDTH-1:0]  digit;
   logic [PROD_WIDTH-1:0]   prod;
   logic                    prod_sat;
   logic [VALUE_WIDTH-1:0]  acc_digit;
   logic                    ovf_digit;
   logic                    blank;
   logic                    numeric;

   assign key_bytes = key_pattern;
   assign blank     = is_blank(text_byte);
   assign numeric   = is_digit(text_byte);

   // key compare at the current match position
   assign hit      = (pos_ff < key_len) && (key_bytes[pos_ff[SEL_WIDTH-1:0]] == text_byte);
   assign pos_step = hit ? pos_ff + POS_WIDTH'(1) : '0;

   // accumulate: a fresh number starts from zero when the first digit arrives
   assign acc_base  = (phase_ff == PH_BLANK) ? '0 : acc_ff;
   assign ovf_base  = (phase_ff == PH_BLANK) ? 1'b0 : ovf_ff;
   assign digit     = DIGIT_WIDTH'(text_byte - CHAR_ZERO);
   assign prod      = (PROD_WIDTH'(acc_base) << 3) + (PROD_WIDTH'(acc_base) << 1)
                      + PROD_WIDTH'(digit);
   assign prod_sat  = (prod[PROD_WIDTH-1:VALUE_WIDTH] != '0);
   assign acc_digit = prod_sat ? VALUE_MAX : prod[VALUE_WIDTH-1:0];
   assign ovf_digit = ovf_base | prod_sat;

   // phase update for one byte
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      unique case (phase_ff)
         PH_KEY: begin
            pos_in = pos_step;
            if (pos_step >= key_len) begin
               phase_in = PH_COLON;
            end
         end
         PH_COLON: begin
            if (!blank) begin
               if (text_byte == CHAR_COLON) begin
                  phase_in = PH_BLANK;
               end else begin
                  phase_in = PH_KEY;
                  pos_in   = '0;
               end
            end
         end
         PH_BLANK: begin
            if (!blank) begin
               if (numeric) begin
                  acc_in   = acc_digit;
                  ovf_in   = ovf_digit;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_KEY;
                  pos_in   = '0;
               end
            end
         end
         PH_DIGITS: begin
            if (numeric) begin
               acc_in = acc_digit;
               ovf_in = ovf_digit;
            end else begin
               phase_in = PH_DONE;
            end
         end
         default: phase_in = PH_DONE;
      endcase
   end

   // result of a text, taken from the updated state
   always_comb begin
      result.valid = beat_accept && last_byte;
      if ((phase_in == PH_DIGITS) || (phase_in == PH_DONE)) begin
         result.value    = acc_in;
         result.status   = STATUS_FOUND;
         result.overflow = ovf_in;
      end else begin
         result.value    = '0;
         result.overflow = 1'b0;
         case (phase_in)
            PH_KEY:   result.status = STATUS_NO_KEY;
            PH_COLON: result.status = STATUS_NO_COLON;
            default:  result.status = STATUS_NO_DIGITS;
         endcase
      end
   end

   // scan state, cleared on reset and after the last byte of a text
   always_ff @(posedge clock) begin
      if (reset || (beat_accept && last_byte)) begin
         phase_ff <= PH_KEY;
         pos_ff   <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (beat_accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

>>> hw/rtl/kcis_out.sv
module kcis_out import kcis_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       slot_ready,
   kcis_rsp_if.source rsp
);

   logic                    valid_ff;
   logic [VALUE_WIDTH-1:0]  value_ff;
   status_type              status_ff;
   logic                    ovf_ff;

   // slot is free, or its beat leaves this cycle
   assign slot_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (result.valid) begin
         value_ff  <= result.value;
         status_ff <= result.status;
         ovf_ff    <= result.overflow;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.number_value   = value_ff;
   assign rsp.scan_status    = STATUS_WIDTH'(status_ff);
   assign rsp.value_overflow = ovf_ff;

endmodule

>>> hw/rtl/key_colon_integer_scanner_core.sv
// channel  | dir | payload                                      | handshake
// req      | in  | text_byte[7:0], last_byte                    | valid / ready
// rsp      | out | number_value[30:0], scan_status[1:0], ovf    | valid / ready
// csr      | in  | csr_index[0], csr_write_data[63:0]           | csr_write_enable
//
// one byte per cycle while req.ready is high; the scan state updates at the edge that takes the byte
// a last byte's result is written into the output register at the edge that takes that byte
// req.ready drops only while the output register is full and rsp.ready is low
// reset is synchronous, active high; key_pattern = 0, key_length = 1 after it
`include "assert_macros.svh"

module key_colon_integer_scanner_core import kcis_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   kcis_req_if.sink                   req,
   kcis_rsp_if.source                 rsp,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic                 slot_ready;
   logic                 beat_accept;
   logic [KEY_WIDTH-1:0] key_pattern;
   logic [POS_WIDTH-1:0] key_len;
   result_type           result;

   assign req.ready   = slot_ready;
   assign beat_accept = req.valid && slot_ready;

   // configuration registers
   kcis_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .key_pattern      (key_pattern),
      .key_len          (key_len)
   );

   // per-byte scanner
   kcis_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .text_byte   (req.text_byte),
      .last_byte   (req.last_byte),
      .key_pattern (key_pattern),
      .key_len     (key_len),
      .result      (result)
   );

   // output register
   kcis_out u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .slot_ready (slot_ready),
      .rsp        (rsp)
   );

   // checks
   `ASSERT_IMPL(a_stall_blocks_input, rsp.valid && !rsp.ready, !req.ready, "input taken while output stalled")
   `ASSERT_NEXT(a_last_gives_result, req.valid && req.ready && req.last_byte, rsp.valid, "last byte gave no result")
   `ASSERT_IMPL(a_fail_value_zero, rsp.valid && (rsp.scan_status != STATUS_FOUND), (rsp.number_value == '0) && !rsp.value_overflow, "failed scan carries a value")
   `ASSERT_HOLDS(a_result_only_on_last, !result.valid || (beat_accept && req.last_byte), "result without a last byte")

endmodule
